@@ rtl/core/atp_pkg.sv @@
// Shared types, constants and coefficient tables for the arctangent pipeline.
`timescale 1ns / 1ps
`default_nettype none
package atp_pkg;

    localparam int DATA_WIDTH   = 32;
    localparam int FRAC_BITS    = 30;
    localparam int COEF_FRAC    = 60;
    localparam int TW           = 40;                 // signed Horner value
    localparam int MW           = TW - 1;             // magnitude of a Horner value
    localparam int SW           = 33;                 // x squared, unsigned
    localparam int DIV_STEPS    = 32;                 // quotient bits, one per stage
    localparam int HORNER_STEPS = 5;
    localparam int STEP_STAGES  = 3;
    localparam int PIPE_DEPTH   = 3 + HORNER_STEPS * STEP_STAGES + 1 + DIV_STEPS + 3;

    typedef logic signed [TW-1:0] t_val;
    typedef logic [SW-1:0]        t_sq;

    typedef struct packed {
        logic [MW-1:0]                rem;
        logic [MW-1:0]                den;
        logic [DIV_STEPS-1:0]         quo;
        logic                         neg;
        logic signed [DATA_WIDTH-1:0] x;
    } t_div_word;

    // Q60 constant to Q(FRAC_BITS), magnitude rounded half away from zero
    function automatic t_val f_coef(input logic signed [63:0] c);
        logic [63:0] m;
        logic [63:0] r;
        m = c;
        if (c < 0) begin
            m = 64'd0 - m;
        end
        r = (m >> (COEF_FRAC - FRAC_BITS)) + ((m >> (COEF_FRAC - FRAC_BITS - 1)) & 64'd1);
        if (c < 0) begin
            return t_val'(-$signed({1'b0, r[MW-1:0]}));
        end
        return t_val'($signed({1'b0, r[MW-1:0]}));
    endfunction

    // numerator: start value P4, then P3..P0, last step adds nothing (p = s*t)
    localparam t_val NUM_T0 = f_coef(-64'sd7824362901665297);
    localparam t_val NUM_STEP [0:HORNER_STEPS-1] = '{
        f_coef(-64'sd123772144987453957),
        f_coef(-64'sd514335909323355293),
        f_coef(-64'sd775934472941750981),
        f_coef(-64'sd384307168202282325),
        t_val'(0)
    };

    // denominator: start value Q5, then Q4..Q0
    localparam t_val DEN_T0 = f_coef(64'sd9060826304364361);
    localparam t_val DEN_STEP [0:HORNER_STEPS-1] = '{
        f_coef(64'sd196317903261227813),
        f_coef(64'sd1177907419567366880),
        f_coef(64'sd2860632304663605279),
        f_coef(64'sd3019556321589361128),
        f_coef(64'sd1152921504606846976)
    };

endpackage
`default_nettype wire

@@ rtl/core/atp_arg_if.sv @@
// Input channel: argument word with valid/ready.
`timescale 1ns / 1ps
`default_nettype none
interface atp_arg_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [atp_pkg::DATA_WIDTH-1:0] arg_in;

    modport source (output valid, output arg_in, input ready);
    modport sink   (input valid, input arg_in, output ready);
endinterface
`default_nettype wire

@@ rtl/core/atp_angle_if.sv @@
// Output channel: angle word with valid/ready.
`timescale 1ns / 1ps
`default_nettype none
interface atp_angle_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [atp_pkg::DATA_WIDTH-1:0] angle_out;

    modport source (output valid, output angle_out, input ready);
    modport sink   (input valid, input angle_out, output ready);
endinterface
`default_nettype wire

@@ rtl/core/atp_horner_step.sv @@
// One Horner step t_out = coef + s*t, three register stages.
`timescale 1ns / 1ps
`default_nettype none
module atp_horner_step (
    input  wire                 i_clk,
    input  wire                 i_en,
    input  atp_pkg::t_sq        i_s,
    input  atp_pkg::t_val       i_t,
    input  atp_pkg::t_val       i_coef,
    output atp_pkg::t_val       o_t
);
    localparam int LO = 20;
    localparam int HI = atp_pkg::MW - LO;
    localparam int PW = atp_pkg::SW + atp_pkg::MW + 1;
    localparam logic [PW-1:0] RND = PW'(1) << (atp_pkg::FRAC_BITS - 1);

    atp_pkg::t_val              t_abs;
    logic [atp_pkg::MW-1:0]     tmag;
    logic [atp_pkg::SW+LO-1:0]  n_pp_lo, r_pp_lo;
    logic [atp_pkg::SW+HI-1:0]  n_pp_hi, r_pp_hi;
    logic                       r_neg1, r_neg2;
    logic [PW-1:0]              sum;
    logic [atp_pkg::MW-1:0]     n_mag, r_mag;
    atp_pkg::t_val              n_t, r_t;

    // split the multiplier into two narrow partial products
    always_comb begin
        t_abs   = i_t[atp_pkg::TW-1] ? -i_t : i_t;
        tmag    = t_abs[atp_pkg::MW-1:0];
        n_pp_lo = {{LO{1'b0}}, i_s} * {{atp_pkg::SW{1'b0}}, tmag[LO-1:0]};
        n_pp_hi = {{HI{1'b0}}, i_s} * {{atp_pkg::SW{1'b0}}, tmag[atp_pkg::MW-1:LO]};
    end

    // recombine, round half away from zero on the magnitude
    always_comb begin
        sum   = PW'(r_pp_lo) + (PW'(r_pp_hi) << LO) + RND;
        n_mag = sum[atp_pkg::FRAC_BITS+atp_pkg::MW-1:atp_pkg::FRAC_BITS];
    end

    always_comb begin
        if (r_neg2) begin
            n_t = i_coef - $signed({1'b0, r_mag});
        end else begin
            n_t = i_coef + $signed({1'b0, r_mag});
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pp_lo <= n_pp_lo;
            r_pp_hi <= n_pp_hi;
            r_neg1  <= i_t[atp_pkg::TW-1];
            r_mag   <= n_mag;
            r_neg2  <= r_neg1;
            r_t     <= n_t;
        end
    end

    assign o_t = r_t;
endmodule
`default_nettype wire

@@ rtl/core/atp_div_stage.sv @@
// One restoring-division stage: one quotient bit per cycle while i_en is high.
`timescale 1ns / 1ps
`default_nettype none
module atp_div_stage (
    input  wire                 i_clk,
    input  wire                 i_en,
    input  atp_pkg::t_div_word  i_w,
    output atp_pkg::t_div_word  o_w
);
    logic [atp_pkg::MW:0]  trial;
    logic [atp_pkg::MW:0]  diff;
    logic                  ge;
    atp_pkg::t_div_word    n_w, r_w;

    always_comb begin
        trial = {i_w.rem, i_w.quo[atp_pkg::DIV_STEPS-1]};
        diff  = trial - {1'b0, i_w.den};
        ge    = trial >= {1'b0, i_w.den};
        n_w   = i_w;
        n_w.rem = ge ? diff[atp_pkg::MW-1:0] : trial[atp_pkg::MW-1:0];
        n_w.quo = {i_w.quo[atp_pkg::DIV_STEPS-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_w <= n_w;
        end
    end

    assign o_w = r_w;
endmodule
`default_nettype wire

@@ rtl/core/arctan_pade_rational.sv @@
// Pipeline: 54 register stages between an accepted argument word and its angle word.
// Throughput: one word per cycle; the whole pipeline advances when the output
//   register is empty or being taken, otherwise every stage holds.
// Depth is set by the 32-stage restoring divider for p/q and the 15 stages of
//   the two parallel Horner chains (three stages per multiply-add).
// Reset: synchronous active-low; clears only the per-stage valid bits.
`timescale 1ns / 1ps
`default_nettype none
module arctan_pade_rational (
    input  wire               i_clk,
    input  wire               i_rst_n,
    atp_arg_if.sink           i_arg,
    atp_angle_if.source       o_angle
);
    localparam int DW     = atp_pkg::DATA_WIDTH;
    localparam int FB     = atp_pkg::FRAC_BITS;
    localparam int ND     = atp_pkg::PIPE_DEPTH;
    localparam int NH     = atp_pkg::HORNER_STEPS;
    localparam int HSTG   = NH * atp_pkg::STEP_STAGES;
    localparam int SDLY   = (NH - 1) * atp_pkg::STEP_STAGES;
    localparam int NDIV   = atp_pkg::DIV_STEPS;
    localparam int LOWB   = NDIV - FB;     // dividend bits below the initial remainder

    logic              en;
    logic [ND-1:0]     r_vld;

    // stage 0: input register
    logic signed [DW-1:0]  r_x0;
    // stage 1: x*x
    logic [DW-1:0]         xmag0;
    logic [2*DW-1:0]       r_sq;
    logic signed [DW-1:0]  r_x1;
    // stage 2: s = round(x*x)
    logic [2*DW:0]         sq_rnd;
    atp_pkg::t_sq          r_s;
    logic signed [DW-1:0]  r_x2;

    // global stall: everything moves when the output slot frees up
    assign en          = !r_vld[ND-1] || o_angle.ready;
    assign i_arg.ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[ND-2:0], i_arg.valid};
        end
    end

    always_comb begin
        xmag0  = r_x0[DW-1] ? DW'(-r_x0) : DW'(r_x0);
        sq_rnd = {1'b0, r_sq} + ((2*DW+1)'(1) << (FB - 1));
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_x0 <= i_arg.arg_in;
            r_sq <= xmag0 * xmag0;
            r_x1 <= r_x0;
            r_s  <= sq_rnd[FB+atp_pkg::SW-1:FB];
            r_x2 <= r_x1;
        end
    end

    // s delay line feeding the Horner steps after the first; x rides alongside
    atp_pkg::t_sq          r_sd [0:SDLY-1];
    logic signed [DW-1:0]  r_xh [0:HSTG-1];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sd[0] <= r_s;
            r_xh[0] <= r_x2;
            for (int i = 1; i < SDLY; i++) begin
                r_sd[i] <= r_sd[i-1];
            end
            for (int i = 1; i < HSTG; i++) begin
                r_xh[i] <= r_xh[i-1];
            end
        end
    end

    // numerator and denominator Horner chains, in lockstep
    atp_pkg::t_sq   s_tap [0:NH-1];
    atp_pkg::t_val  num_t [0:NH];
    atp_pkg::t_val  den_t [0:NH];

    assign num_t[0] = atp_pkg::NUM_T0;
    assign den_t[0] = atp_pkg::DEN_T0;

    for (genvar k = 0; k < NH; k++) begin : g_horner
        if (k == 0) begin : g_first
            assign s_tap[k] = r_s;
        end else begin : g_rest
            assign s_tap[k] = r_sd[k*atp_pkg::STEP_STAGES-1];
        end

        atp_horner_step u_num (
            .i_clk  (i_clk),
            .i_en   (en),
            .i_s    (s_tap[k]),
            .i_t    (num_t[k]),
            .i_coef (atp_pkg::NUM_STEP[k]),
            .o_t    (num_t[k+1])
        );

        atp_horner_step u_den (
            .i_clk  (i_clk),
            .i_en   (en),
            .i_s    (s_tap[k]),
            .i_t    (den_t[k]),
            .i_coef (atp_pkg::DEN_STEP[k]),
            .o_t    (den_t[k+1])
        );
    end

    // divider setup: |p| scaled by 2^FB over q; q is always positive
    atp_pkg::t_val        p_abs;
    atp_pkg::t_div_word   n_dw0;
    atp_pkg::t_div_word   dw [0:NDIV];

    always_comb begin
        p_abs     = num_t[NH][atp_pkg::TW-1] ? -num_t[NH] : num_t[NH];
        n_dw0.rem = {{LOWB{1'b0}}, p_abs[atp_pkg::MW-1:LOWB]};
        n_dw0.den = den_t[NH][atp_pkg::MW-1:0];
        n_dw0.quo = {p_abs[LOWB-1:0], {FB{1'b0}}};
        n_dw0.neg = num_t[NH][atp_pkg::TW-1];
        n_dw0.x   = r_xh[HSTG-1];
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            dw[0] <= n_dw0;
        end
    end

    for (genvar k = 0; k < NDIV; k++) begin : g_div
        atp_div_stage u_div (
            .i_clk (i_clk),
            .i_en  (en),
            .i_w   (dw[k]),
            .o_w   (dw[k+1])
        );
    end

    // round the quotient, form 1 + p/q
    logic                 q_up;
    logic [NDIV:0]        q_res;
    logic signed [NDIV+1:0] q_sgn;
    logic signed [NDIV+1:0] z;
    logic signed [NDIV+1:0] z_abs;
    logic [DW-1:0]        r_zmag;
    logic                 r_zneg;
    logic signed [DW-1:0] r_xr;

    always_comb begin
        q_up  = {dw[NDIV].rem, 1'b0} >= {1'b0, dw[NDIV].den};
        q_res = {1'b0, dw[NDIV].quo} + (NDIV+1)'(q_up);
        q_sgn = dw[NDIV].neg ? -$signed({1'b0, q_res}) : $signed({1'b0, q_res});
        z     = ((NDIV+2)'(1) <<< FB) + q_sgn;
        z_abs = z[NDIV+1] ? -z : z;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_zmag <= z_abs[DW-1:0];
            r_zneg <= z[NDIV+1];
            r_xr   <= dw[NDIV].x;
        end
    end

    // final multiply x * (1 + p/q)
    logic [DW-1:0]   xmag_r;
    logic [2*DW-1:0] r_prod;
    logic            r_pneg;

    assign xmag_r = r_xr[DW-1] ? DW'(-r_xr) : DW'(r_xr);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_prod <= xmag_r * r_zmag;
            r_pneg <= r_xr[DW-1] ^ r_zneg;
        end
    end

    // round, apply sign, clamp to the output range
    localparam logic [DW+2:0] POS_LIM = (DW+3)'(1) << (DW - 1);
    logic [2*DW:0]        out_rnd;
    logic [DW+2:0]        out_mag;
    logic signed [DW-1:0] n_y, r_y;

    always_comb begin
        out_rnd = {1'b0, r_prod} + ((2*DW+1)'(1) << (FB - 1));
        out_mag = out_rnd[FB+DW+2:FB];
        if (r_pneg) begin
            if (out_mag > POS_LIM) begin
                n_y = {1'b1, {(DW-1){1'b0}}};
            end else begin
                n_y = DW'(-out_mag[DW-1:0]);
            end
        end else begin
            if (out_mag >= POS_LIM) begin
                n_y = {1'b0, {(DW-1){1'b1}}};
            end else begin
                n_y = out_mag[DW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_y <= n_y;
        end
    end

    assign o_angle.valid     = r_vld[ND-1];
    assign o_angle.angle_out = r_y;
endmodule
`default_nettype wire
